### src/csvtok_pkg.sv
// Shared constants and types for the CSV line field tokenizer.
// No dependencies; imported by csv_line_field_tokenizer_unit and its bench.
package csvtok_pkg;

    // Field widths of the byte stream and of the result
    localparam int BYTE_W  = 8;
    localparam int FNUM_W  = 10;
    localparam int FLEN_W  = 16;

    // Configuration register indexes
    localparam logic CFG_DELIMITER  = 1'b0;
    localparam logic CFG_WS_MODE    = 1'b1;

    // Reset value of the delimiter register (comma)
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h2C;

    // Special characters
    localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] TAB_BYTE   = 8'h09;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              field_end;
        logic              line_end;
        logic [FNUM_W-1:0] field_number;
        logic [FLEN_W-1:0] field_length;
    } t_tok_result;

endpackage

### src/csv_line_field_tokenizer_unit.sv
// CSV line field tokenizer: top level, parser state and result register.
// Depends on csvtok_pkg.
//
// Takes one line byte per transaction on the slave stream (tlast high marks the
// end-of-line transaction, whose data is ignored) and gives at most one result
// per transaction on the master stream. Each transaction is handled in the cycle
// it is accepted: the parser state and the result register update at that edge,
// so the block sustains one byte per clock unless the master side stalls. The
// result register is the only stage; while a result waits, a new transaction
// is still taken in the same cycle the result leaves, and transactions that
// give no result (opening quote, pending quote, extra separators) never
// occupy it. Configuration writes take effect on the next byte.
module csv_line_field_tokenizer_unit
    import csvtok_pkg::*;
#(
    parameter int MAX_FIELDS    = 1024,
    parameter int MAX_FIELD_LEN = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  logic        s_axis_tlast,   // cmd (end of line)
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [17:8] field_number,
                                        // [33:18] field_length, [39:34] zero
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] field_end
    output logic        m_axis_tlast    // line_end
);

    // Saturation limits
    localparam int FIELD_CAP_I = (MAX_FIELDS - 1 < 1023) ? MAX_FIELDS - 1 : 1023;
    localparam int LEN_CAP_I   = (MAX_FIELD_LEN < 65535) ? MAX_FIELD_LEN : 65535;
    localparam logic [FNUM_W-1:0] FIELD_CAP = FNUM_W'(FIELD_CAP_I);
    localparam logic [FLEN_W-1:0] LEN_CAP   = FLEN_W'(LEN_CAP_I);

    // Configuration
    logic [BYTE_W-1:0] r_delim;
    logic              r_ws_mode;

    // Parser state
    logic              r_inside_quotes, n_inside_quotes;
    logic              r_quote_opened,  n_quote_opened;
    logic              r_quote_pending, n_quote_pending;
    logic              r_field_has,     n_field_has;
    logic [FNUM_W-1:0] r_field_cnt,     n_field_cnt;
    logic [FLEN_W-1:0] r_len_cnt,       n_len_cnt;

    // Result register
    logic              r_out_valid;
    t_tok_result       r_out;
    t_tok_result       n_out;
    logic              n_emit;

    logic              in_acc;
    logic              out_acc;
    logic [BYTE_W-1:0] c;
    logic              is_quote;
    logic              is_sep;
    logic              inq_eff;
    logic [FLEN_W-1:0] len_inc;
    logic [FNUM_W-1:0] fcnt_inc;

    assign out_acc       = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign c        = s_axis_tdata;
    assign is_quote = (c == QUOTE_BYTE);
    assign is_sep   = (c == SPACE_BYTE) || (c == TAB_BYTE);
    assign inq_eff  = r_quote_pending ? 1'b0 : r_inside_quotes;
    assign len_inc  = (r_len_cnt < LEN_CAP) ? r_len_cnt + 1'b1 : r_len_cnt;
    assign fcnt_inc = (r_field_cnt < FIELD_CAP) ? r_field_cnt + 1'b1 : r_field_cnt;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim   <= DELIM_RESET;
            r_ws_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DELIMITER: r_delim   <= i_cfg_wdata;
                CFG_WS_MODE:   r_ws_mode <= i_cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // Decide the next state and the result for the offered transaction
    always_comb begin
        n_inside_quotes = r_inside_quotes;
        n_quote_opened  = r_quote_opened;
        n_quote_pending = r_quote_pending;
        n_field_has     = r_field_has;
        n_field_cnt     = r_field_cnt;
        n_len_cnt       = r_len_cnt;
        n_emit          = 1'b0;

        n_out.out_byte     = '0;
        n_out.byte_valid   = 1'b0;
        n_out.field_end    = 1'b0;
        n_out.line_end     = 1'b0;
        n_out.field_number = r_field_cnt;
        n_out.field_length = r_len_cnt;

        if (s_axis_tlast) begin
            // end of line: close the last field, clear the line state
            n_emit          = 1'b1;
            n_out.line_end  = 1'b1;
            n_out.field_end = r_ws_mode ? r_field_has : 1'b1;
            n_inside_quotes = 1'b0;
            n_quote_opened  = 1'b0;
            n_quote_pending = 1'b0;
            n_field_has     = 1'b0;
            n_field_cnt     = '0;
            n_len_cnt       = '0;
        end else if (r_ws_mode) begin
            if (is_sep) begin
                if (r_field_has) begin
                    n_emit          = 1'b1;
                    n_out.field_end = 1'b1;
                    n_field_cnt     = fcnt_inc;
                    n_len_cnt       = '0;
                    n_field_has     = 1'b0;
                    n_quote_opened  = 1'b0;
                end
            end else begin
                n_emit             = 1'b1;
                n_out.out_byte     = c;
                n_out.byte_valid   = 1'b1;
                n_out.field_length = len_inc;
                n_len_cnt          = len_inc;
                n_field_has        = 1'b1;
            end
        end else begin
            n_quote_pending = 1'b0;
            n_inside_quotes = inq_eff;
            if (r_quote_pending && is_quote) begin
                // doubled quote: one literal quote, stay inside
                n_inside_quotes    = r_inside_quotes;
                n_emit             = 1'b1;
                n_out.out_byte     = c;
                n_out.byte_valid   = 1'b1;
                n_out.field_length = len_inc;
                n_len_cnt          = len_inc;
                n_field_has        = 1'b1;
            end else if (is_quote && !r_quote_opened && !r_field_has) begin
                // opening quote at the start of an empty field
                n_inside_quotes = 1'b1;
                n_quote_opened  = 1'b1;
            end else if (is_quote && inq_eff) begin
                // hold the quote until the next byte decides
                n_quote_pending = 1'b1;
            end else if (!is_quote && (c == r_delim) && !inq_eff) begin
                n_emit          = 1'b1;
                n_out.field_end = 1'b1;
                n_field_cnt     = fcnt_inc;
                n_len_cnt       = '0;
                n_field_has     = 1'b0;
                n_quote_opened  = 1'b0;
            end else begin
                n_emit             = 1'b1;
                n_out.out_byte     = c;
                n_out.byte_valid   = 1'b1;
                n_out.field_length = len_inc;
                n_len_cnt          = len_inc;
                n_field_has        = 1'b1;
            end
        end
    end

    // Advance the parser state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_quotes <= 1'b0;
            r_quote_opened  <= 1'b0;
            r_quote_pending <= 1'b0;
            r_field_has     <= 1'b0;
            r_field_cnt     <= '0;
            r_len_cnt       <= '0;
        end else if (in_acc) begin
            r_inside_quotes <= n_inside_quotes;
            r_quote_opened  <= n_quote_opened;
            r_quote_pending <= n_quote_pending;
            r_field_has     <= n_field_has;
            r_field_cnt     <= n_field_cnt;
            r_len_cnt       <= n_len_cnt;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.field_length, r_out.field_number, r_out.out_byte};
    assign m_axis_tuser  = {r_out.field_end, r_out.byte_valid};
    assign m_axis_tlast  = r_out.line_end;

    // A result never carries both a content byte and a field end
    a_byte_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.byte_valid && r_out.field_end))
        else $error("result has both byte_valid and field_end");

    // A content byte always counts at least one byte
    a_byte_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.byte_valid) |-> (r_out.field_length != '0))
        else $error("content byte with zero field length");

    // A pending quote only exists inside quotes
    a_pending_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quote_pending |-> r_inside_quotes)
        else $error("quote pending outside quotes");

    // End of line clears the line state
    a_eol_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tlast) |=>
            (r_field_cnt == '0) && (r_len_cnt == '0) && !r_field_has && !r_quote_pending)
        else $error("line state not cleared after end of line");

endmodule

### test/tb_csv_line_field_tokenizer_unit.sv
// Self-checking bench for csv_line_field_tokenizer_unit: streams line bytes and
// end-of-line transactions, predicts every token in a scoreboard class and checks it.
// Depends on csvtok_pkg and the tokenizer RTL.
module tb_csv_line_field_tokenizer_unit
    import csvtok_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_CAP      = 1023;
    localparam int LEN_CAP        = 65535;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ITEMS_PER_PASS = 105;
    localparam int NUM_PASSES     = 8;
    localparam int PRINT_LIMIT    = 50;

    // Kind of a slave transaction, carried on tlast
    localparam logic LINE_BYTE = 1'b0;
    localparam logic LINE_END  = 1'b1;

    // Per-pass delimiter (pass 0 in the low byte) and mode (pass 0 in bit 0)
    localparam logic [8*NUM_PASSES-1:0] PASS_DELIMS =
        {8'h7C, 8'h09, 8'hFF, 8'h20, 8'h22, 8'h00, 8'h3B, 8'h2C};
    localparam logic [NUM_PASSES-1:0] PASS_WS_MODE = 8'b1101_0010;

    // Token predictor and store of expected tokens
    class csv_token_scoreboard;
        logic [BYTE_W-1:0] delim;
        logic              ws_mode;
        logic              is_quoted;
        logic              quote_open;
        logic              quote_pend;
        logic              has_bytes;
        logic [FNUM_W-1:0] field_idx;
        logic [FLEN_W-1:0] field_len;
        t_tok_result       expected_tokens[$];
        int                mismatches;
        int                tokens_checked;
        int                bytes_in;
        int                lines_in;

        function new();
            delim          = DELIM_RESET;
            ws_mode        = 1'b0;
            mismatches     = 0;
            tokens_checked = 0;
            bytes_in       = 0;
            lines_in       = 0;
            clear_line();
        endfunction

        function void clear_line();
            is_quoted  = 1'b0;
            quote_open = 1'b0;
            quote_pend = 1'b0;
            has_bytes  = 1'b0;
            field_idx  = '0;
            field_len  = '0;
        endfunction

        function void push_token(logic [BYTE_W-1:0] b, logic bv, logic fe, logic le);
            t_tok_result r;
            r.out_byte     = b;
            r.byte_valid   = bv;
            r.field_end    = fe;
            r.line_end     = le;
            r.field_number = field_idx;
            r.field_length = field_len;
            expected_tokens.insert(expected_tokens.size(), r);
        endfunction

        function void push_content(logic [BYTE_W-1:0] b);
            if (field_len < LEN_CAP) field_len++;
            has_bytes = 1'b1;
            push_token(b, 1'b1, 1'b0, 1'b0);
        endfunction

        function void push_field_end();
            push_token('0, 1'b0, 1'b1, 1'b0);
            if (field_idx < FIELD_CAP) field_idx++;
            field_len  = '0;
            has_bytes  = 1'b0;
            quote_open = 1'b0;
        endfunction

        // Advance the parser by one accepted slave transaction
        function void note_item(logic kind, logic [BYTE_W-1:0] c);
            if (kind == LINE_END) begin
                lines_in++;
                push_token('0, 1'b0, ws_mode ? has_bytes : 1'b1, 1'b1);
                clear_line();
                return;
            end
            bytes_in++;
            if (ws_mode) begin
                if (c == SPACE_BYTE || c == TAB_BYTE) begin
                    if (has_bytes) push_field_end();
                end else begin
                    push_content(c);
                end
                return;
            end
            // A pending quote is resolved by the byte that follows it
            if (quote_pend) begin
                quote_pend = 1'b0;
                if (c == QUOTE_BYTE) begin
                    push_content(c);
                    return;
                end
                is_quoted = 1'b0;
            end
            if (c == QUOTE_BYTE) begin
                if (!quote_open && !has_bytes) begin
                    is_quoted  = 1'b1;
                    quote_open = 1'b1;
                end else if (is_quoted) begin
                    quote_pend = 1'b1;
                end else begin
                    push_content(c);
                end
            end else if (c == delim && !is_quoted) begin
                push_field_end();
            end else begin
                push_content(c);
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                report_mismatch($sformatf("token %0d %s: expected %0d, got %0d",
                                          tokens_checked, name, want, got));
        endtask

        // Check one master transaction against the oldest expected token
        task check_token(t_tok_result got);
            t_tok_result want;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("token with none expected: %p", got));
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            compare_field("field_end", 32'(want.field_end), 32'(got.field_end));
            compare_field("line_end", 32'(want.line_end), 32'(got.line_end));
            compare_field("field_number", 32'(want.field_number), 32'(got.field_number));
            compare_field("field_length", 32'(want.field_length), 32'(got.field_length));
            tokens_checked++;
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = CFG_DELIMITER;
    logic [7:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] line_byte
    logic        s_axis_tlast  = 1'b0; // cmd (end of line)
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [7:0] out_byte, [17:8] field_number,
                                       // [33:18] field_length, [39:34] zero
    logic [1:0]  m_axis_tuser;         // [0] byte_valid, [1] field_end
    logic        m_axis_tlast;         // line_end

    csv_token_scoreboard tokens = new();
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    csv_line_field_tokenizer_unit uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the master side at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Check results first, then advance the predictor on accepted input
    always @(posedge i_clk) begin
        t_tok_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte     = m_axis_tdata[7:0];
                got.field_number = m_axis_tdata[17:8];
                got.field_length = m_axis_tdata[33:18];
                got.byte_valid   = m_axis_tuser[0];
                got.field_end    = m_axis_tuser[1];
                got.line_end     = m_axis_tlast;
                tokens.check_token(got);
            end
            if (s_axis_tvalid && s_axis_tready) tokens.note_item(s_axis_tlast, s_axis_tdata);
        end
    end

    // Hard stop on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d tokens still expected",
                 cycle_count, tokens.expected_tokens.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tlast  <= kind;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic end_line();
        send_item(LINE_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(LINE_BYTE, s[i]);
    endtask

    // Hold the sender until every expected token is out, then let the block settle
    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        while (tokens.expected_tokens.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain_tokens();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_DELIMITER) tokens.delim = val;
        else tokens.ws_mode = val[0];
    endtask

    // Any byte, weighted toward the ones the parser treats specially
    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0: return QUOTE_BYTE;
            1: return tokens.delim;
            2: return SPACE_BYTE;
            3: return TAB_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == QUOTE_BYTE || b == tokens.delim || b == SPACE_BYTE || b == TAB_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? SPACE_BYTE : TAB_BYTE;
    endfunction

    // Well-formed delimited line: empty, plain and quoted fields
    task automatic send_quoted_line();
        int nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++) begin
            if (f != 0) send_item(LINE_BYTE, tokens.delim);
            case ($urandom_range(0, 3))
                0: ;
                1: repeat ($urandom_range(1, 6)) send_item(LINE_BYTE, plain_byte());
                default: begin
                    send_item(LINE_BYTE, QUOTE_BYTE);
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 5))
                            0: begin
                                send_item(LINE_BYTE, QUOTE_BYTE);
                                send_item(LINE_BYTE, QUOTE_BYTE);
                            end
                            1: send_item(LINE_BYTE, tokens.delim);
                            2: send_item(LINE_BYTE, blank_byte());
                            default: send_item(LINE_BYTE, plain_byte());
                        endcase
                    end
                    send_item(LINE_BYTE, QUOTE_BYTE);
                    if ($urandom_range(0, 3) == 0) send_item(LINE_BYTE, plain_byte());
                end
            endcase
        end
        end_line();
    endtask

    // Well-formed blank-separated line with leading and trailing runs
    task automatic send_spaced_line();
        int nfields = $urandom_range(0, 4);
        logic [7:0] b;
        repeat ($urandom_range(0, 2)) send_item(LINE_BYTE, blank_byte());
        for (int f = 0; f < nfields; f++) begin
            if (f != 0) repeat ($urandom_range(1, 3)) send_item(LINE_BYTE, blank_byte());
            repeat ($urandom_range(1, 6)) begin
                do b = any_byte(); while (b == SPACE_BYTE || b == TAB_BYTE);
                send_item(LINE_BYTE, b);
            end
        end
        repeat ($urandom_range(0, 2)) send_item(LINE_BYTE, blank_byte());
        end_line();
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(0, 10)) send_item(LINE_BYTE, any_byte());
        end_line();
    endtask

    initial begin
        int  target;
        bit  paused;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(CFG_DELIMITER, DELIM_RESET);
        write_reg(CFG_WS_MODE, 8'h00);

        // Open quote, doubled quote, close, empty field, quote in a plain field
        send_text("\"a\"\"b\",,x\"y");
        end_line();
        // Byte extremes in one field
        send_item(LINE_BYTE, 8'h00);
        send_item(LINE_BYTE, 8'hFF);
        end_line();
        // Quote still pending at end of line
        send_text("\"z\"");
        end_line();

        // Switch to blank-separated mode in the middle of an open quoted field
        send_text("\"p ");
        write_reg(CFG_WS_MODE, 8'h01);
        send_text(" q\t");
        end_line();

        // Random passes over delimiter, mode and idle profiles
        for (int p = 0; p < NUM_PASSES; p++) begin
            write_reg(CFG_DELIMITER, PASS_DELIMS[8*p +: 8]);
            write_reg(CFG_WS_MODE, {7'b0, PASS_WS_MODE[p]});
            src_idle_pct  = (p % 4 == 1) ? 79 : (p % 4 == 3) ? 9 : 0;
            snk_stall_pct = (p % 4 == 2) ? 79 : (p % 4 == 3) ? 9 : 0;
            target = items_sent + ITEMS_PER_PASS;
            paused = 1'b0;
            while (items_sent < target) begin
                if (!paused && items_sent >= target - ITEMS_PER_PASS / 2) begin
                    drain_tokens();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0) send_noise_line();
                else if (tokens.ws_mode) send_spaced_line();
                else send_quoted_line();
            end
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        drain_tokens();
        repeat (8) @(negedge i_clk);

        $display("Ran %0d lines, %0d line bytes, %0d tokens checked; delimited and blank modes,",
                 tokens.lines_in, tokens.bytes_in, tokens.tokens_checked);
        $display("delimiter extremes, quoting cases, a mid-line mode switch and four idle profiles.");
        if (tokens.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", tokens.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
